### src/tnt_pkg.sv
`timescale 1ns / 1ps
package tnt_pkg;

   localparam int DATA_W = 32;
   localparam int DIFF_W = 33;
   localparam int ACC_W  = 68;
   localparam int NORM_W = 16;
   localparam int TAN_W  = 32;

   // One triangle's edge and texture differences, handed from front to back.
   typedef struct packed {
      logic signed [DIFF_W-1:0] e1x;
      logic signed [DIFF_W-1:0] e1y;
      logic signed [DIFF_W-1:0] e1z;
      logic signed [DIFF_W-1:0] e2x;
      logic signed [DIFF_W-1:0] e2y;
      logic signed [DIFF_W-1:0] e2z;
      logic signed [DIFF_W-1:0] fx;
      logic signed [DIFF_W-1:0] fy;
      logic signed [DIFF_W-1:0] fz;
      logic signed [DIFF_W-1:0] du1;
      logic signed [DIFF_W-1:0] dv1;
      logic signed [DIFF_W-1:0] du2;
      logic signed [DIFF_W-1:0] dv2;
   } job_type;

   // Magnitude of a signed accumulator value.
   function automatic logic [ACC_W-1:0] abs_acc(input logic signed [ACC_W-1:0] v);
      abs_acc = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
   endfunction

endpackage

### src/triangle_normal_and_tangent.sv
`timescale 1ns / 1ps
// The back end finishes one triangle before it takes the next; its pace is set by
// the serial divider shared by six quotients.
// Vertices are taken every cycle while the two-entry job queue has room.
// Synchronous active-high reset clears the corner store, the queue and the sequencer.
module triangle_normal_and_tangent #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,   // normal_x/y/z, tangent_x/y/z
   output logic [1:0]   rsp_tuser    // flat_face, flat_uv
);
   import tnt_pkg::*;

   job_type job;
   logic    job_valid, job_ready;

   tnt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job)
   );

   tnt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef NO_ASSERTIONS
   // A flat face carries a zero normal.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[47:0] == '0)
      else $error("flat face with nonzero normal");

   // A flat uv mapping carries a zero tangent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata[143:48] == '0)
      else $error("flat uv with nonzero tangent");

   // The normal x component stays within unit length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[15:0]) <= 16'sd16384 &&
                     $signed(rsp_tdata[15:0]) >= -16'sd16384)
      else $error("normal x out of range");

   // No result right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");
`endif

endmodule

### src/tnt_front.sv
`timescale 1ns / 1ps
module tnt_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [159:0]     req_tdata,
   output logic             job_valid,
   input  logic             job_ready,
   output tnt_pkg::job_type job
);
   import tnt_pkg::*;

   logic signed [DATA_W-1:0] held_pos_ff [6];
   logic signed [DATA_W-1:0] held_tex_ff [4];
   logic [1:0]               corner_ff;
   job_type                  queue_ff [2];
   logic                     wp_ff, rp_ff;
   logic [1:0]               fill_ff;
   logic signed [DATA_W-1:0] px, py, pz, tu, tv;
   job_type                  job_in;
   logic                     take, push, pop;

   assign px = req_tdata[31:0];
   assign py = req_tdata[63:32];
   assign pz = req_tdata[95:64];
   assign tu = req_tdata[127:96];
   assign tv = req_tdata[159:128];

   assign req_tready = (fill_ff != 2'd2);
   assign take       = req_tvalid && req_tready;
   assign push       = take && (corner_ff >= 2'd2);
   assign job_valid  = (fill_ff != 2'd0);
   assign pop        = job_valid && job_ready;
   assign job        = queue_ff[rp_ff];

   // Differences of the three corners, all exact in 33 bits.
   always_comb begin
      job_in.e1x = DIFF_W'(held_pos_ff[3]) - DIFF_W'(held_pos_ff[0]);
      job_in.e1y = DIFF_W'(held_pos_ff[4]) - DIFF_W'(held_pos_ff[1]);
      job_in.e1z = DIFF_W'(held_pos_ff[5]) - DIFF_W'(held_pos_ff[2]);
      job_in.e2x = DIFF_W'(px) - DIFF_W'(held_pos_ff[0]);
      job_in.e2y = DIFF_W'(py) - DIFF_W'(held_pos_ff[1]);
      job_in.e2z = DIFF_W'(pz) - DIFF_W'(held_pos_ff[2]);
      job_in.fx  = DIFF_W'(px) - DIFF_W'(held_pos_ff[3]);
      job_in.fy  = DIFF_W'(py) - DIFF_W'(held_pos_ff[4]);
      job_in.fz  = DIFF_W'(pz) - DIFF_W'(held_pos_ff[5]);
      job_in.du1 = DIFF_W'(held_tex_ff[2]) - DIFF_W'(held_tex_ff[0]);
      job_in.dv1 = DIFF_W'(held_tex_ff[3]) - DIFF_W'(held_tex_ff[1]);
      job_in.du2 = DIFF_W'(tu) - DIFF_W'(held_tex_ff[0]);
      job_in.dv2 = DIFF_W'(tv) - DIFF_W'(held_tex_ff[1]);
   end

   // Corner store, corner count and the two-entry job queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff <= 2'd0;
         wp_ff     <= 1'b0;
         rp_ff     <= 1'b0;
         fill_ff   <= 2'd0;
         for (int i = 0; i < 6; i++) held_pos_ff[i] <= '0;
         for (int i = 0; i < 4; i++) held_tex_ff[i] <= '0;
      end else begin
         if (take) begin
            if (corner_ff == 2'd0) begin
               held_pos_ff[0] <= px;
               held_pos_ff[1] <= py;
               held_pos_ff[2] <= pz;
               held_tex_ff[0] <= tu;
               held_tex_ff[1] <= tv;
               corner_ff      <= 2'd1;
            end else if (corner_ff == 2'd1) begin
               held_pos_ff[3] <= px;
               held_pos_ff[4] <= py;
               held_pos_ff[5] <= pz;
               held_tex_ff[2] <= tu;
               held_tex_ff[3] <= tv;
               corner_ff      <= 2'd2;
            end else begin
               corner_ff <= 2'd0;
            end
         end
         if (push) begin
            queue_ff[wp_ff] <= job_in;
            wp_ff           <= ~wp_ff;
         end
         if (pop) rp_ff <= ~rp_ff;
         if (push && !pop) fill_ff <= fill_ff + 2'd1;
         else if (pop && !push) fill_ff <= fill_ff - 2'd1;
      end
   end

endmodule

### src/tnt_div.sv
`timescale 1ns / 1ps
module tnt_div #(
   parameter int NUM_W = 84,
   parameter int DEN_W = 68
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [33:0]      quo,
   output logic             ovf,
   output logic [DEN_W-1:0] rem
);
   import tnt_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] n_ff;
   logic [DEN_W-1:0] d_ff, r_ff;
   logic [33:0]      q_ff;
   logic             ovf_ff, run_ff, done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W:0]   r_shift, r_diff;
   logic             ge;

   // Restoring division, one quotient bit per cycle.
   assign r_shift = {r_ff, n_ff[NUM_W-1]};
   assign ge      = (r_shift >= {1'b0, d_ff});
   assign r_diff  = r_shift - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !start && run_ff && (cnt_ff == CNT_W'(1));
         if (start) begin
            n_ff   <= num;
            d_ff   <= den;
            r_ff   <= '0;
            q_ff   <= '0;
            ovf_ff <= 1'b0;
            cnt_ff <= CNT_W'(NUM_W);
            run_ff <= 1'b1;
         end else if (run_ff) begin
            n_ff   <= n_ff << 1;
            r_ff   <= ge ? r_diff[DEN_W-1:0] : r_shift[DEN_W-1:0];
            q_ff   <= {q_ff[32:0], ge};
            ovf_ff <= ovf_ff | q_ff[33];
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) run_ff <= 1'b0;
         end
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;
   assign ovf  = ovf_ff;
   assign rem  = r_ff;

endmodule

### src/tnt_back.sv
`timescale 1ns / 1ps
module tnt_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  tnt_pkg::job_type job,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [143:0]     rsp_tdata,
   output logic [1:0]       rsp_tuser
);
   import tnt_pkg::*;

   localparam int NUM_W = ACC_W + FRAC_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_ABS, S_NORM, S_SQ, S_SQRT, S_DIV_GO, S_DIV_WAIT
   } state_type;

   state_type                 state_ff;
   logic                      out_pend_ff;
   job_type                   job_ff;
   logic [3:0]                step_ff, pidx_ff;
   logic signed [ACC_W-1:0]   acc_ff [7];
   logic signed [2*DIFF_W-1:0] prod_ff, prod;
   logic signed [DIFF_W-1:0]  mul_a, mul_b;
   logic [ACC_W-1:0]          mag_ff [3];
   logic [ACC_W-1:0]          mag_or;
   logic [63:0]               s_ff, sq_rem_ff, sq_res_ff, sq_bit_ff, sq_try;
   logic [2:0]                idx_ff;
   logic                      flat_face_ff, flat_uv_ff;
   logic signed [NORM_W-1:0]  norm_ff [3];
   logic signed [TAN_W-1:0]   tan_ff [3];
   logic                      rsp_valid_ff;
   logic [143:0]              rsp_data_ff;
   logic [1:0]                rsp_user_ff;
   logic                      div_start_ff, div_done, div_ovf;
   logic [NUM_W-1:0]          div_num_ff;
   logic [ACC_W-1:0]          div_den_ff, div_rem;
   logic [33:0]               div_quo;
   logic [ACC_W-1:0]          tan_mag, den_mag;
   logic [34:0]               q_round;
   logic [32:0]               lim;
   logic                      t_neg, round_up, sat;
   logic [TAN_W-1:0]          t_mag;
   logic [NORM_W-1:0]         n_mag;

   tnt_div #(.NUM_W(NUM_W), .DEN_W(ACC_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quo   (div_quo),
      .ovf   (div_ovf),
      .rem   (div_rem)
   );

   // Operand select for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_SQ) begin
         case (step_ff[1:0])
            2'd0: mul_a = DIFF_W'({1'b0, mag_ff[0][29:0]});
            2'd1: mul_a = DIFF_W'({1'b0, mag_ff[1][29:0]});
            2'd2: mul_a = DIFF_W'({1'b0, mag_ff[2][29:0]});
            default: mul_a = '0;
         endcase
         mul_b = mul_a;
      end else begin
         case (step_ff)
            4'd0:  begin mul_a = job_ff.e1y; mul_b = job_ff.fz;  end
            4'd1:  begin mul_a = job_ff.e1z; mul_b = job_ff.fy;  end
            4'd2:  begin mul_a = job_ff.e1z; mul_b = job_ff.fx;  end
            4'd3:  begin mul_a = job_ff.e1x; mul_b = job_ff.fz;  end
            4'd4:  begin mul_a = job_ff.e1x; mul_b = job_ff.fy;  end
            4'd5:  begin mul_a = job_ff.e1y; mul_b = job_ff.fx;  end
            4'd6:  begin mul_a = job_ff.du1; mul_b = job_ff.dv2; end
            4'd7:  begin mul_a = job_ff.du2; mul_b = job_ff.dv1; end
            4'd8:  begin mul_a = job_ff.dv2; mul_b = job_ff.e1x; end
            4'd9:  begin mul_a = job_ff.dv1; mul_b = job_ff.e2x; end
            4'd10: begin mul_a = job_ff.dv2; mul_b = job_ff.e1y; end
            4'd11: begin mul_a = job_ff.dv1; mul_b = job_ff.e2y; end
            4'd12: begin mul_a = job_ff.dv2; mul_b = job_ff.e1z; end
            4'd13: begin mul_a = job_ff.dv1; mul_b = job_ff.e2z; end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
   end

   assign prod    = mul_a * mul_b;
   assign mag_or  = mag_ff[0] | mag_ff[1] | mag_ff[2];
   assign sq_try  = sq_res_ff + sq_bit_ff;
   assign tan_mag = abs_acc(acc_ff[3'(idx_ff + 3'd1)]);
   assign den_mag = abs_acc(acc_ff[3]);

   // Rounding and saturation of a finished tangent quotient.
   assign t_neg    = acc_ff[3'(idx_ff + 3'd1)][ACC_W-1] ^ acc_ff[3][ACC_W-1];
   assign lim      = t_neg ? 33'h080000000 : 33'h07FFFFFFF;
   assign round_up = ({div_rem, 1'b0} >= {1'b0, div_den_ff});
   assign q_round  = {1'b0, div_quo} + 35'(round_up);
   assign sat      = div_ovf || (q_round > {2'b00, lim});
   assign t_mag    = sat ? lim[31:0] : q_round[31:0];
   assign n_mag    = div_quo[NORM_W-1:0];

   assign job_ready = (state_ff == S_IDLE) && !out_pend_ff;

   // Sequencer: products, normalization, square root, divisions, result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= (state_ff == S_DIV_GO);
         if (out_pend_ff && (!rsp_valid_ff || rsp_tready)) begin
            rsp_data_ff  <= {tan_ff[2], tan_ff[1], tan_ff[0],
                             norm_ff[2], norm_ff[1], norm_ff[0]};
            rsp_user_ff  <= {flat_uv_ff, flat_face_ff};
            rsp_valid_ff <= 1'b1;
            out_pend_ff  <= 1'b0;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (job_valid && !out_pend_ff) begin
                  job_ff  <= job;
                  step_ff <= 4'd0;
                  for (int k = 0; k < 7; k++) acc_ff[k] <= '0;
                  for (int k = 0; k < 3; k++) begin
                     norm_ff[k] <= '0;
                     tan_ff[k]  <= '0;
                  end
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               if (step_ff != 4'd14) begin
                  prod_ff <= prod;
                  pidx_ff <= step_ff;
               end
               if (step_ff != 4'd0) begin
                  if (pidx_ff[0])
                     acc_ff[pidx_ff[3:1]] <= acc_ff[pidx_ff[3:1]] - ACC_W'(prod_ff);
                  else
                     acc_ff[pidx_ff[3:1]] <= acc_ff[pidx_ff[3:1]] + ACC_W'(prod_ff);
               end
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'd14) state_ff <= S_ABS;
            end
            S_ABS: begin
               for (int k = 0; k < 3; k++) mag_ff[k] <= abs_acc(acc_ff[k]);
               flat_face_ff <= (acc_ff[0] == '0) && (acc_ff[1] == '0) &&
                               (acc_ff[2] == '0);
               flat_uv_ff   <= (acc_ff[3] == '0);
               if ((acc_ff[0] == '0) && (acc_ff[1] == '0) && (acc_ff[2] == '0)) begin
                  if (acc_ff[3] == '0) begin
                     out_pend_ff <= 1'b1;
                     state_ff    <= S_IDLE;
                  end else begin
                     idx_ff   <= 3'd3;
                     state_ff <= S_DIV_GO;
                  end
               end else begin
                  state_ff <= S_NORM;
               end
            end
            S_NORM: begin
               // Bring the largest magnitude to a bit length of 30.
               if (|mag_or[ACC_W-1:30]) begin
                  for (int k = 0; k < 3; k++) mag_ff[k] <= mag_ff[k] >> 1;
               end else if (!mag_or[29]) begin
                  for (int k = 0; k < 3; k++) mag_ff[k] <= mag_ff[k] << 1;
               end else begin
                  step_ff  <= 4'd0;
                  s_ff     <= '0;
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               if (step_ff != 4'd3) prod_ff <= prod;
               if (step_ff != 4'd0) s_ff <= s_ff + prod_ff[63:0];
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'd3) begin
                  sq_rem_ff <= s_ff + prod_ff[63:0];
                  sq_res_ff <= '0;
                  sq_bit_ff <= 64'h4000000000000000;
                  state_ff  <= S_SQRT;
               end
            end
            S_SQRT: begin
               // Integer square root, one result bit per cycle.
               if (sq_bit_ff == '0) begin
                  idx_ff   <= 3'd0;
                  state_ff <= S_DIV_GO;
               end else begin
                  if (sq_rem_ff >= sq_try) begin
                     sq_rem_ff <= sq_rem_ff - sq_try;
                     sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
                  end else begin
                     sq_res_ff <= sq_res_ff >> 1;
                  end
                  sq_bit_ff <= sq_bit_ff >> 2;
               end
            end
            S_DIV_GO: begin
               if (idx_ff < 3'd3) begin
                  div_num_ff <= NUM_W'({mag_ff[idx_ff[1:0]][29:0], 14'd0}) +
                                NUM_W'(sq_res_ff >> 1);
                  div_den_ff <= ACC_W'(sq_res_ff);
               end else begin
                  div_num_ff <= NUM_W'(tan_mag) << FRAC_BITS;
                  div_den_ff <= den_mag;
               end
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  if (idx_ff < 3'd3) begin
                     norm_ff[idx_ff[1:0]] <= acc_ff[idx_ff][ACC_W-1] ?
                                             NORM_W'(-n_mag) : n_mag;
                  end else begin
                     tan_ff[2'(idx_ff - 3'd3)] <= t_neg ? TAN_W'(-t_mag) : t_mag;
                  end
                  if ((idx_ff == 3'd2 && flat_uv_ff) || idx_ff == 3'd5) begin
                     out_pend_ff <= 1'b1;
                     state_ff    <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + 3'd1;
                     state_ff <= S_DIV_GO;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### tb/sv/triangle_normal_and_tangent_tb.sv
`timescale 1ns / 1ps
module triangle_normal_and_tangent_tb;
   import tnt_pkg::*;

   localparam int FRAC = 16;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int DRAIN_CYCLES = 800;
   localparam int RANDOM_VERTICES = 576;
   localparam int QUIET_TAIL = 60;

   // One expected face result in the block's packing.
   typedef struct {
      logic [143:0] data;
      logic [1:0]   flags;
   } face_result_type;

   // Tracks the held corners and the queue of face results still owed.
   class face_scoreboard;
      logic signed [31:0] corner_pos[2][3];
      logic signed [31:0] corner_uv[2][2];
      int                 corners_held;
      face_result_type    owed[$];
      int                 mismatches;

      function new();
         corners_held = 0;
         mismatches = 0;
         foreach (corner_pos[i, k]) corner_pos[i][k] = '0;
         foreach (corner_uv[i, k]) corner_uv[i][k] = '0;
      endfunction

      // Integer square root by the digit-pair method.
      function automatic logic [63:0] int_sqrt(logic [63:0] s);
         logic [63:0] res;
         logic [63:0] bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > s) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (s >= res + bitv) begin
               s = s - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      // Rounded, saturated quotient num * 2^FRAC / den; den is nonzero.
      function automatic logic [31:0] tangent_quotient(logic signed [69:0] num,
                                                       logic signed [69:0] den);
         logic         neg;
         logic [127:0] n;
         logic [127:0] d;
         logic [127:0] q;
         logic [127:0] r;
         logic [127:0] lim;
         neg = num[69] != den[69];
         n = 128'(num[69] ? -num : num) << FRAC;
         d = 128'(den[69] ? -den : den);
         q = n / d;
         r = n % d;
         if ((r << 1) >= d) q = q + 1;
         lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
         if (q > lim) q = lim;
         return neg ? 32'(-q) : 32'(q);
      endfunction

      function automatic face_result_type predict_face(logic signed [31:0] p2[3],
                                                       logic signed [31:0] u2,
                                                       logic signed [31:0] v2);
         face_result_type    res;
         logic signed [32:0] e1[3];
         logic signed [32:0] e2[3];
         logic signed [32:0] f[3];
         logic signed [32:0] du1, dv1, du2, dv2;
         logic signed [69:0] cprod[3];
         logic [69:0]        mag[3];
         logic [63:0]        mm[3];
         logic [63:0]        sum_sq, root, n;
         logic signed [69:0] den;
         int                 top;
         for (int k = 0; k < 3; k++) begin
            e1[k] = 33'(corner_pos[1][k]) - 33'(corner_pos[0][k]);
            e2[k] = 33'(p2[k]) - 33'(corner_pos[0][k]);
            f[k]  = 33'(p2[k]) - 33'(corner_pos[1][k]);
         end
         cprod[0] = e1[1] * f[2] - e1[2] * f[1];
         cprod[1] = e1[2] * f[0] - e1[0] * f[2];
         cprod[2] = e1[0] * f[1] - e1[1] * f[0];
         res.data = '0;
         res.flags = '0;

         // Normal: align the largest magnitude to 30 bits, then divide by the root.
         top = 0;
         for (int k = 0; k < 3; k++) begin
            mag[k] = cprod[k][69] ? 70'(-cprod[k]) : 70'(cprod[k]);
            for (int b = 69; b >= 0; b--) begin
               if (mag[k][b]) begin
                  if (b + 1 > top) top = b + 1;
                  break;
               end
            end
         end
         if (top == 0) begin
            res.flags[0] = 1'b1;
         end else begin
            sum_sq = 0;
            for (int k = 0; k < 3; k++) begin
               mm[k] = top > 30 ? 64'(mag[k] >> (top - 30)) : 64'(mag[k] << (30 - top));
               sum_sq = sum_sq + mm[k] * mm[k];
            end
            root = int_sqrt(sum_sq);
            for (int k = 0; k < 3; k++) begin
               n = ((mm[k] << 14) + (root >> 1)) / root;
               if (cprod[k][69]) n = -n;
               res.data[16*k +: 16] = n[15:0];
            end
         end

         // Tangent from the uv determinant.
         du1 = 33'(corner_uv[1][0]) - 33'(corner_uv[0][0]);
         dv1 = 33'(corner_uv[1][1]) - 33'(corner_uv[0][1]);
         du2 = 33'(u2) - 33'(corner_uv[0][0]);
         dv2 = 33'(v2) - 33'(corner_uv[0][1]);
         den = du1 * dv2 - du2 * dv1;
         if (den == 0) begin
            res.flags[1] = 1'b1;
         end else begin
            for (int k = 0; k < 3; k++) begin
               res.data[48 + 32*k +: 32] = tangent_quotient(dv2 * e1[k] - dv1 * e2[k], den);
            end
         end
         return res;
      endfunction

      // An accepted vertex: hold it, or finish a triangle and owe its result.
      function void note_vertex(logic [159:0] beat);
         logic signed [31:0] p[3];
         for (int k = 0; k < 3; k++) p[k] = beat[32*k +: 32];
         if (corners_held < 2) begin
            corner_pos[corners_held] = p;
            corner_uv[corners_held][0] = beat[96 +: 32];
            corner_uv[corners_held][1] = beat[128 +: 32];
            corners_held++;
         end else begin
            owed = {owed, predict_face(p, beat[96 +: 32], beat[128 +: 32])};
            corners_held = 0;
         end
      endfunction

      function void report(string what, logic [31:0] want, logic [31:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h", what, want, got);
      endfunction

      // A result beat: compare each field against the oldest owed result.
      function void check_result(logic [143:0] data, logic [1:0] flags);
         face_result_type want;
         string           names[6] = '{"normal_x", "normal_y", "normal_z",
                                       "tangent_x", "tangent_y", "tangent_z"};
         if (owed.size() == 0) begin
            report("unexpected result beat", 32'h0, 32'(data));
            return;
         end
         want = owed.pop_front();
         for (int k = 0; k < 3; k++) begin
            if (data[16*k +: 16] !== want.data[16*k +: 16])
               report(names[k], 32'(want.data[16*k +: 16]), 32'(data[16*k +: 16]));
            if (data[48 + 32*k +: 32] !== want.data[48 + 32*k +: 32])
               report(names[3+k], want.data[48 + 32*k +: 32], data[48 + 32*k +: 32]);
         end
         if (flags[0] !== want.flags[0]) report("flat_face", 32'(want.flags[0]), 32'(flags[0]));
         if (flags[1] !== want.flags[1]) report("flat_uv", 32'(want.flags[1]), 32'(flags[1]));
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [159:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [143:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   face_scoreboard faces;
   logic [159:0]   vertex_list[$];
   int             vertex_beats;
   int             cycle_count;
   logic           quiet;

   triangle_normal_and_tangent #(.FRAC_BITS(FRAC)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Watch both channels at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            faces.note_vertex(req_tdata);
            vertex_beats++;
         end
         if (rsp_tvalid && rsp_tready) faces.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver stalls in random bursts, none once the tail starts.
   initial begin : result_stalls
      int run;
      rsp_tready = 1'b0;
      run = 0;
      forever begin
         @(negedge clock);
         if (run > 0) begin
            run--;
         end else if (quiet) begin
            rsp_tready <= 1'b1;
         end else begin
            run = $urandom_range(0, 15);
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   function automatic logic [159:0] pack_vertex(logic [31:0] x, logic [31:0] y,
                                                logic [31:0] z, logic [31:0] u,
                                                logic [31:0] v);
      return {v, u, z, y, x};
   endfunction

   // Append one vertex beat to the send list.
   function automatic void queue_vertex(logic [159:0] beat);
      vertex_list = {vertex_list, beat};
   endfunction

   function automatic logic [31:0] pick_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 2 << 20)) - (1 << 20));
         2: return 32'($signed($urandom_range(0, 64)) - 32);
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0;
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   // Queue one triangle of a chosen flavor.
   task automatic add_random_triangle();
      logic [31:0] c[3][5];
      int          flavor;
      int          mode;
      flavor = $urandom_range(0, 9);
      mode = $urandom_range(0, 3);
      foreach (c[i, k]) c[i][k] = pick_coord(mode);
      case (flavor)
         // Collinear or repeated corners give a flat face.
         0: for (int k = 0; k < 3; k++) c[2][k] = c[1][k];
         1: for (int k = 0; k < 3; k++) c[1][k] = c[0][k];
         // Repeated texture coordinates give a flat uv.
         2: begin
            c[2][3] = c[0][3];
            c[2][4] = c[0][4];
         end
         3: begin
            c[1][3] = c[0][3];
            c[2][3] = c[0][3];
         end
         // Tiny uv spread against a large edge drives saturation.
         4: begin
            c[1][3] = c[0][3] + 1;
            c[2][4] = c[0][4] + 1;
            c[1][4] = c[0][4];
            c[2][3] = c[0][3];
         end
         default: ;
      endcase
      for (int i = 0; i < 3; i++)
         queue_vertex(pack_vertex(c[i][0], c[i][1], c[i][2], c[i][3], c[i][4]));
   endtask

   task automatic build_directed();
      logic [31:0] mx, mn, one;
      mx = 32'h7fff_ffff;
      mn = 32'h8000_0000;
      one = 32'h0001_0000;
      // Right triangle in the xy plane, unit uv.
      queue_vertex(pack_vertex(0, 0, 0, 0, 0));
      queue_vertex(pack_vertex(one, 0, 0, one, 0));
      queue_vertex(pack_vertex(0, one, 0, 0, one));
      // All-zero triangle: both flat flags.
      repeat (3) queue_vertex(pack_vertex(0, 0, 0, 0, 0));
      // Field extremes.
      queue_vertex(pack_vertex(mx, mn, mx, mn, mx));
      queue_vertex(pack_vertex(mn, mx, mn, mx, mn));
      queue_vertex(pack_vertex(mx, mx, mn, mn, mn));
      queue_vertex(pack_vertex(mn, mn, mn, mx, mn));
      queue_vertex(pack_vertex(mx, mn, mx, mx, mx));
      queue_vertex(pack_vertex(mx, mx, mx, mn, mx));
      // Collinear corners: flat face, valid uv.
      queue_vertex(pack_vertex(0, 0, 0, 0, 0));
      queue_vertex(pack_vertex(one, one, one, one, 0));
      queue_vertex(pack_vertex(2 * one, 2 * one, 2 * one, 0, one));
      // Smallest uv determinant under a large edge saturates the tangent.
      queue_vertex(pack_vertex(mn, 0, 0, 0, 0));
      queue_vertex(pack_vertex(mx, 1, 0, 1, 0));
      queue_vertex(pack_vertex(0, mx, 7, 0, 1));
      // Negative determinant.
      queue_vertex(pack_vertex(0, 0, 0, 0, 0));
      queue_vertex(pack_vertex(one, 0, 0, 0, one));
      queue_vertex(pack_vertex(0, 0, one, one, 0));
   endtask

   // Sender with random gaps; valid stays high across back-to-back beats.
   task automatic send_vertices();
      int sent;
      int gap;
      sent = 0;
      @(negedge clock);
      while (vertex_list.size() > 0) begin
         quiet = vertex_list.size() <= QUIET_TAIL;
         req_tdata <= vertex_list.pop_front();
         req_tvalid <= 1'b1;
         sent++;
         // Hold the beat until the block has taken it.
         do @(negedge clock); while (vertex_beats < sent);
         gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
         if (gap > 0 || vertex_list.size() == 0) begin
            req_tvalid <= 1'b0;
            req_tdata <= 160'($urandom);
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   initial begin : stimulus
      int waited;
      faces = new();
      vertex_beats = 0;
      cycle_count = 0;
      quiet = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      build_directed();
      while (vertex_list.size() < 24 + RANDOM_VERTICES) add_random_triangle();
      send_vertices();

      // Drain: wait for every owed result, then a latency's worth more.
      while (faces.owed.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (faces.mismatches == 0 && faces.owed.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
